FILE: hdl/gdfw_pkg.sv
package gdfw_pkg;

	// widths of the item and result fields and of the config data
	localparam int FIELD_W = 4;
	localparam int CFG_W   = 4;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] MOVE_WRITE   = 2'd0;
	localparam logic [1:0] MOVE_STEP    = 2'd1;
	localparam logic [1:0] MOVE_BACK    = 2'd2;
	localparam logic [1:0] MOVE_RESTART = 2'd3;

	// neighbor probe order
	localparam logic [1:0] DIR_XP = 2'd0;
	localparam logic [1:0] DIR_YM = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_XM = 2'd3;

	// configuration register indexes
	localparam logic CFG_START_X = 1'b0;
	localparam logic CFG_START_Y = 1'b1;

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] cell_x;
		logic [FIELD_W-1:0] cell_y;
		logic               cell_open;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] walker_x;
		logic [FIELD_W-1:0] walker_y;
		logic [1:0]         move_kind;
	} out_t;

endpackage

FILE: hdl/grid_depth_first_walker.sv
// load item: result in the next cycle; the block stays idle and can take the next item while the result shows.
// tick: each neighbor probed takes a read of the open and seen maps (PROBE) and a check (CHECK),
// then a forward step, or a back-up (FAIL, then POP) via a registered path-stack read.
// restart: the probes, then a sweep over every cell clearing the seen map.
// after reset the block stays busy while it sweeps every cell clearing both maps;
// config writes are taken meanwhile. results show for one cycle; the receiver cannot stall.
module grid_depth_first_walker
	import gdfw_pkg::*;
#(
	parameter int GRID_SIDE   = 16,
	parameter int STACK_DEPTH = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              item,
	output logic             done,
	output out_t             result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW      = $clog2(GRID_SIDE);
	localparam int CELLS   = GRID_SIDE * GRID_SIDE;
	localparam int IW      = $clog2(CELLS);
	localparam int SAW     = $clog2(STACK_DEPTH);
	localparam int LW      = $clog2(STACK_DEPTH + 1);
	localparam int EW      = 2 * CW;
	localparam int RESET_X = 0;
	localparam int RESET_Y = (GRID_SIDE > 15) ? 15 : GRID_SIDE - 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROBE = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_FAIL  = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;

	logic [2:0]       state_q;
	logic [1:0]       dir_q;
	logic [LW-1:0]    len_q;
	logic [IW-1:0]    clr_q;
	logic             clr_open_q;
	logic [CW-1:0]    top_x_q, top_y_q;
	logic [CW-1:0]    base_x_q, base_y_q;
	logic [CW-1:0]    nbr_x_q, nbr_y_q;
	logic [IW-1:0]    nbr_idx_q;
	logic [FIELD_W-1:0] start_x_q, start_y_q;
	logic             done_q;
	out_t             result_q;

	logic [CW-1:0]    nbr_x, nbr_y;
	logic             nbr_ok;
	logic [IW-1:0]    nbr_idx;
	logic [CW-1:0]    start_cx, start_cy;
	logic             accept, load_in_grid, push;
	logic [IW-1:0]    load_idx;
	logic [CW-1:0]    pop_x, pop_y;

	logic             open_mem [CELLS];
	logic             seen_mem [CELLS];
	logic [EW-1:0]    stack_mem [STACK_DEPTH];
	logic             open_rd_q, seen_rd_q;
	logic [EW-1:0]    stack_rd_q;
	logic             open_we, open_wd, seen_we, seen_wd;
	logic [IW-1:0]    open_wa, seen_wa;

	// shared neighbor address unit
	gdfw_step #(
		.GRID_SIDE(GRID_SIDE)
	) u_step (
		.top_x  (top_x_q),
		.top_y  (top_y_q),
		.dir    (dir_q),
		.nbr_x  (nbr_x),
		.nbr_y  (nbr_y),
		.nbr_ok (nbr_ok),
		.nbr_idx(nbr_idx)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= FIELD_W'(0);
			start_y_q <= FIELD_W'(15);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// start cell saturated into the grid
	assign start_cx = ({4'd0, start_x_q} >= 8'(GRID_SIDE)) ? CW'(GRID_SIDE - 1) : CW'(start_x_q);
	assign start_cy = ({4'd0, start_y_q} >= 8'(GRID_SIDE)) ? CW'(GRID_SIDE - 1) : CW'(start_y_q);

	// load item decode
	assign accept       = start && !busy;
	assign load_in_grid = ({4'd0, item.cell_x} < 8'(GRID_SIDE)) &&
	                      ({4'd0, item.cell_y} < 8'(GRID_SIDE));
	assign load_idx     = IW'(IW'(item.cell_y) * IW'(GRID_SIDE) + IW'(item.cell_x));

	// forward step when the probed neighbor is open and unseen
	assign push = (state_q == ST_CHECK) && open_rd_q && !seen_rd_q;

	// map write ports: clearing sweep, cell load, visit mark
	always_comb begin
		open_we = ((state_q == ST_CLEAR) && clr_open_q) ||
		          (accept && (item.op == OP_LOAD) && load_in_grid);
		open_wa = (state_q == ST_CLEAR) ? clr_q : load_idx;
		open_wd = (state_q == ST_CLEAR) ? 1'b0 : item.cell_open;
		seen_we = (state_q == ST_CLEAR) || push;
		seen_wa = (state_q == ST_CLEAR) ? clr_q : nbr_idx_q;
		seen_wd = (state_q != ST_CLEAR);
	end

	// open map
	always_ff @(posedge clk) begin
		if (open_we) begin
			open_mem[open_wa] <= open_wd;
		end
		open_rd_q <= open_mem[nbr_idx];
	end

	// seen map
	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_wa] <= seen_wd;
		end
		seen_rd_q <= seen_mem[nbr_idx];
	end

	// path stack above entry zero, read one below the current top for a back-up
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[len_q[SAW-1:0]] <= {nbr_y_q, nbr_x_q};
		end
		stack_rd_q <= stack_mem[SAW'(len_q - LW'(2))];
	end

	// cell uncovered by a back-up
	assign pop_x = (len_q == LW'(1)) ? base_x_q : stack_rd_q[CW-1:0];
	assign pop_y = (len_q == LW'(1)) ? base_y_q : stack_rd_q[EW-1:CW];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			dir_q      <= DIR_XP;
			len_q      <= LW'(1);
			clr_q      <= '0;
			clr_open_q <= 1'b1;
			top_x_q    <= CW'(RESET_X);
			top_y_q    <= CW'(RESET_Y);
			base_x_q   <= CW'(RESET_X);
			base_y_q   <= CW'(RESET_Y);
			nbr_x_q    <= '0;
			nbr_y_q    <= '0;
			nbr_idx_q  <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.op == OP_LOAD) begin
							done_q   <= 1'b1;
							result_q <= '{walker_x: FIELD_W'(top_x_q),
							              walker_y: FIELD_W'(top_y_q),
							              move_kind: MOVE_WRITE};
						end else begin
							dir_q   <= DIR_XP;
							state_q <= (len_q < LW'(STACK_DEPTH)) ? ST_PROBE : ST_FAIL;
						end
					end
				end
				ST_PROBE: begin
					if (nbr_ok) begin
						nbr_x_q   <= nbr_x;
						nbr_y_q   <= nbr_y;
						nbr_idx_q <= nbr_idx;
						state_q   <= ST_CHECK;
					end else if (dir_q == DIR_XM) begin
						state_q <= ST_FAIL;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ST_CHECK: begin
					if (push) begin
						top_x_q  <= nbr_x_q;
						top_y_q  <= nbr_y_q;
						len_q    <= len_q + LW'(1);
						done_q   <= 1'b1;
						result_q <= '{walker_x: FIELD_W'(nbr_x_q),
						              walker_y: FIELD_W'(nbr_y_q),
						              move_kind: MOVE_STEP};
						state_q  <= ST_IDLE;
					end else if (dir_q == DIR_XM) begin
						state_q <= ST_FAIL;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= ST_PROBE;
					end
				end
				ST_FAIL: begin
					if (len_q > LW'(1)) begin
						len_q   <= len_q - LW'(1);
						state_q <= ST_POP;
					end else begin
						top_x_q    <= start_cx;
						top_y_q    <= start_cy;
						base_x_q   <= start_cx;
						base_y_q   <= start_cy;
						len_q      <= LW'(1);
						clr_q      <= '0;
						clr_open_q <= 1'b0;
						state_q    <= ST_CLEAR;
					end
				end
				ST_POP: begin
					top_x_q  <= pop_x;
					top_y_q  <= pop_y;
					done_q   <= 1'b1;
					result_q <= '{walker_x: FIELD_W'(pop_x),
					              walker_y: FIELD_W'(pop_y),
					              move_kind: MOVE_BACK};
					state_q  <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
						if (!clr_open_q) begin
							done_q   <= 1'b1;
							result_q <= '{walker_x: FIELD_W'(top_x_q),
							              walker_y: FIELD_W'(top_y_q),
							              move_kind: MOVE_RESTART};
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// a load transfer answers in the next cycle with a write result
	a_load_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == OP_LOAD) |=> (done && result.move_kind == MOVE_WRITE))
		else $error("load item without a write result");

	// a tick transfer keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == OP_TICK) |=> busy)
		else $error("tick accepted without going busy");

	// a forward step grows the path by exactly one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (len_q == $past(len_q) + LW'(1)))
		else $error("path length not advanced on forward step");

	// a restart leaves only the start cell on the path
	a_restart_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.move_kind == MOVE_RESTART) |->
		(len_q == LW'(1) && top_x_q == base_x_q && top_y_q == base_y_q))
		else $error("restart left more than the start cell");

	// results only follow work in the previous cycle
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) != ST_IDLE || $past(start)))
		else $error("result strobe without work behind it");

endmodule

FILE: hdl/gdfw_step.sv
module gdfw_step
	import gdfw_pkg::*;
#(
	parameter int GRID_SIDE = 16,
	parameter int CW        = $clog2(GRID_SIDE),
	parameter int IW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
	input  logic [CW-1:0] top_x,
	input  logic [CW-1:0] top_y,
	input  logic [1:0]    dir,
	output logic [CW-1:0] nbr_x,
	output logic [CW-1:0] nbr_y,
	output logic          nbr_ok,
	output logic [IW-1:0] nbr_idx
);

	// neighbor coordinates and grid bounds check
	always_comb begin
		nbr_x  = top_x;
		nbr_y  = top_y;
		nbr_ok = 1'b0;
		unique case (dir)
			DIR_XP: begin
				nbr_x  = top_x + CW'(1);
				nbr_ok = (top_x != CW'(GRID_SIDE - 1));
			end
			DIR_YM: begin
				nbr_y  = top_y - CW'(1);
				nbr_ok = (top_y != '0);
			end
			DIR_YP: begin
				nbr_y  = top_y + CW'(1);
				nbr_ok = (top_y != CW'(GRID_SIDE - 1));
			end
			DIR_XM: begin
				nbr_x  = top_x - CW'(1);
				nbr_ok = (top_x != '0);
			end
			default: begin
				nbr_ok = 1'b0;
			end
		endcase
	end

	// row-major cell address
	assign nbr_idx = IW'(IW'(nbr_y) * IW'(GRID_SIDE) + IW'(nbr_x));

endmodule
